>>> hdl/lvp_pkg.sv
package lvp_pkg;

    localparam int SETS_DEF      = 64;
    localparam int WAYS_DEF      = 8;
    localparam int TIME_BITS_DEF = 32;

    localparam int SET_IN_W  = 6;
    localparam int WAY_IN_W  = 3;
    localparam int PCT_W     = 7;
    localparam int NOW_W     = 32;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_VICTIM = 1'b1
    } lvp_cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } lvp_state_t;

    typedef struct packed {
        logic valid;
        logic use_instr;
    } lvp_tree_ctl_t;

endpackage

>>> hdl/lvp_ram.sv
module lvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/lvp_tree.sv
module lvp_tree #(
    parameter int WAYS      = lvp_pkg::WAYS_DEF,
    parameter int TIME_BITS = lvp_pkg::TIME_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lvp_pkg::lvp_tree_ctl_t        in_ctl,
    input  logic [WAYS*(TIME_BITS+1)-1:0] in_row,
    output logic                          tree_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lvp_pkg::WAY_IN_W-1:0]  victim_way
);

    localparam int WAY_W   = $clog2(WAYS);
    localparam int LEVELS  = WAY_W;
    localparam int LEAVES  = 1 << LEVELS;
    localparam int ENTRY_W = TIME_BITS + 1;

    typedef struct packed {
        logic [TIME_BITS-1:0] old_stamp;
        logic [WAY_W-1:0]     old_way;
        logic                 ins_ok;
        logic [TIME_BITS-1:0] ins_stamp;
        logic [WAY_W-1:0]     ins_way;
    } node_t;

    // lo covers the lower ways: oldest keeps the lower way on ties,
    // newest instruction line takes the higher way on ties
    function automatic node_t merge(input node_t lo, input node_t hi);
        node_t r;
        r = lo;
        if (hi.old_stamp < lo.old_stamp) begin
            r.old_stamp = hi.old_stamp;
            r.old_way   = hi.old_way;
        end
        if (hi.ins_ok && (!lo.ins_ok || (lo.ins_stamp <= hi.ins_stamp))) begin
            r.ins_ok    = 1'b1;
            r.ins_stamp = hi.ins_stamp;
            r.ins_way   = hi.ins_way;
        end
        return r;
    endfunction

    node_t                  node     [1:2*LEAVES-1];
    node_t                  node_reg [1:LEAVES-1];
    lvp_pkg::lvp_tree_ctl_t ctl_reg  [LEVELS];
    logic                   m_valid_reg;
    logic [lvp_pkg::WAY_IN_W-1:0] victim_reg;
    logic                   adv;
    logic [WAY_W-1:0]       sel_way;

    assign adv = !m_valid_reg || m_ready;

    // leaves straight from the row, padding never wins
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < WAYS) begin : g_real
            assign node[LEAVES+j] = '{
                old_stamp: in_row[j*ENTRY_W +: TIME_BITS],
                old_way:   WAY_W'(j),
                ins_ok:    in_row[j*ENTRY_W + TIME_BITS],
                ins_stamp: in_row[j*ENTRY_W +: TIME_BITS],
                ins_way:   WAY_W'(j)
            };
        end else begin : g_pad
            assign node[LEAVES+j] = '{
                old_stamp: '1,
                old_way:   WAY_W'(j),
                ins_ok:    1'b0,
                ins_stamp: '0,
                ins_way:   WAY_W'(j)
            };
        end
    end

    // one tree level per stage
    for (genvar i = 1; i < LEAVES; i++) begin : g_node
        always_ff @(posedge aclk) begin
            if (adv) begin
                node_reg[i] <= merge(node[2*i], node[2*i+1]);
            end
        end
        assign node[i] = node_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < LEVELS; d++) begin
                ctl_reg[d] <= '0;
            end
        end else if (adv) begin
            for (int d = 0; d < LEVELS - 1; d++) begin
                ctl_reg[d] <= ctl_reg[d+1];
            end
            ctl_reg[LEVELS-1] <= in_ctl;
        end
    end

    assign sel_way = (ctl_reg[0].use_instr && node[1].ins_ok) ? node[1].ins_way
                                                               : node[1].old_way;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= ctl_reg[0].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            victim_reg <= lvp_pkg::WAY_IN_W'(sel_way);
        end
    end

    assign tree_ready = adv;
    assign m_valid    = m_valid_reg;
    assign victim_way = victim_reg;

    a_victim_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (32'(victim_reg) < WAYS || WAYS > 8))
        else $error("victim way beyond the ways of a set");

    a_stall_holds_front: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(ctl_reg[LEVELS-1]))
        else $error("tree input stage moved while the result was stalled");

    a_stall_holds_root: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(ctl_reg[0]))
        else $error("tree root stage moved while the result was stalled");

endmodule

>>> hdl/lru_victim_prob_instr_evict.sv
// channel | dir | signals                           | payload
// s_      | in  | s_tvalid s_tready s_tdata s_tuser | update or victim request
// m_      | out | m_tvalid m_tready m_tdata         | victim way
// cfg_    | in  | cfg_valid cfg_ready cfg_data      | instr_evict_percent
//
// An input transfer reads its set row; in the lookup state that follows, an update writes
// the row back and a victim request enters a registered compare tree, so a new item is
// taken only after the lookup ends, since s_tready is low outside the idle state.
// A victim leaves the tree after log2(WAYS) stages plus the output register.
// After reset a clearing pass writes SETS rows, one per cycle, with s_tready low.
// A stalled result holds the whole tree; a victim request then waits in the lookup
// with s_tready low, so no further item is taken until the tree moves again.
module lru_victim_prob_instr_evict #(
    parameter int SETS      = lvp_pkg::SETS_DEF,
    parameter int WAYS      = lvp_pkg::WAYS_DEF,
    parameter int TIME_BITS = lvp_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // set_index[5:0] way_index[8:6] is_hit[9] is_write[10] line_is_instr[11]
    // time_now[43:12] random_percent[50:44] zero[55:51]
    input  logic [lvp_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // victim_way[2:0] zero[7:3]
    output logic [lvp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lvp_pkg::PCT_W-1:0]       cfg_data
);

    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int ENTRY_W = TIME_BITS + 1;
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam int SIN_W   = lvp_pkg::SET_IN_W;

    function automatic logic [SET_W-1:0] set_wrap(input logic [SIN_W-1:0] raw);
        logic [SIN_W-1:0] r;
        r = raw;
        for (int i = SIN_W - 1; i >= 0; i--) begin
            if (64'(r) >= (64'(SETS) << i)) begin
                r = r - SIN_W'(64'(SETS) << i);
            end
        end
        return SET_W'(r);
    endfunction

    lvp_pkg::lvp_state_t    state_reg, state_next;
    logic [SET_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [lvp_pkg::PCT_W-1:0] pct_reg;

    lvp_pkg::lvp_cmd_t      cmd_reg;
    logic [SET_W-1:0]       set_reg;
    logic [lvp_pkg::WAY_IN_W-1:0] way_reg;
    logic                   hit_reg;
    logic                   wr_reg;
    logic                   instr_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [lvp_pkg::PCT_W-1:0] rnd_reg;

    logic                   in_xfer;
    logic                   ram_we;
    logic [SET_W-1:0]       ram_waddr;
    logic [ROW_W-1:0]       ram_wdata;
    logic [ROW_W-1:0]       ram_rdata;
    logic [ROW_W-1:0]       upd_row;
    logic                   upd_ok;
    logic [WAY_W-1:0]       way_sel;
    lvp_pkg::lvp_tree_ctl_t tree_ctl;
    logic                   tree_ready;
    logic [lvp_pkg::WAY_IN_W-1:0] victim_way;

    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            pct_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg   <= lvp_pkg::lvp_cmd_t'(s_tuser);
            set_reg   <= set_wrap(s_tdata[5:0]);
            way_reg   <= s_tdata[8:6];
            hit_reg   <= s_tdata[9];
            wr_reg    <= s_tdata[10];
            instr_reg <= s_tdata[11];
            now_reg   <= TIME_BITS'(s_tdata[43:12]);
            rnd_reg   <= s_tdata[50:44];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lvp_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            lvp_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(SETS - 1)) begin
                    state_next = lvp_pkg::ST_IDLE;
                end
            end
            lvp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = lvp_pkg::ST_LOOK;
                end
            end
            lvp_pkg::ST_LOOK: begin
                if (cmd_reg == lvp_pkg::CMD_UPDATE || tree_ready) begin
                    state_next = lvp_pkg::ST_IDLE;
                end
            end
            default: state_next = lvp_pkg::ST_CLEAR;
        endcase
    end

    assign upd_ok  = (32'(way_reg) < WAYS) && !(hit_reg && wr_reg);
    assign way_sel = WAY_W'(way_reg);

    always_comb begin
        upd_row = ram_rdata;
        upd_row[way_sel*ENTRY_W +: ENTRY_W] = {instr_reg, now_reg};
    end

    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = upd_row;
        tree_ctl  = '0;
        unique case (state_reg)
            lvp_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            lvp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            lvp_pkg::ST_LOOK: begin
                if (cmd_reg == lvp_pkg::CMD_UPDATE) begin
                    ram_we = upd_ok;
                end else begin
                    tree_ctl.valid     = tree_ready;
                    tree_ctl.use_instr = rnd_reg < pct_reg;
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

    lvp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (set_wrap(s_tdata[5:0])),
        .rdata (ram_rdata)
    );

    lvp_tree #(
        .WAYS      (WAYS),
        .TIME_BITS (TIME_BITS)
    ) u_tree (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_ctl     (tree_ctl),
        .in_row     (ram_rdata),
        .tree_ready (tree_ready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .victim_way (victim_way)
    );

    assign m_tdata = {(lvp_pkg::M_TDATA_W - lvp_pkg::WAY_IN_W)'(0), victim_way};

    a_no_read_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && in_xfer))
        else $error("row read and row write in the same cycle");

    a_xfer_then_look: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == lvp_pkg::ST_LOOK)
        else $error("accepted item did not reach the row lookup");

    a_tree_only_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        tree_ctl.valid |-> (cmd_reg == lvp_pkg::CMD_VICTIM && !ram_we))
        else $error("tree loaded by an update or while writing a row");

endmodule

>>> bench/tb_lru_victim_prob_instr_evict.sv
module tb_lru_victim_prob_instr_evict;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FROM_PREDICTOR = -1;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 200;
    localparam int QUIET_FIRST    = 400;
    localparam int QUIET_LAST     = 549;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        lvp_pkg::lvp_cmd_t            cmd;
        logic [lvp_pkg::SET_IN_W-1:0] set_idx;
        logic [lvp_pkg::WAY_IN_W-1:0] way;
        logic                         hit;
        logic                         wr;
        logic                         instr;
        logic [lvp_pkg::NOW_W-1:0]    tnow;
        logic [lvp_pkg::PCT_W-1:0]    rnd;
    } req_t;

    typedef struct packed {
        req_t req;
        logic signed [7:0] want;
    } probe_t;

    localparam int NPROBES = 22;
    localparam probe_t PROBES [NPROBES] = '{
        '{'{lvp_pkg::CMD_VICTIM, 6'd0, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0}, 8'sd0},
        '{'{lvp_pkg::CMD_VICTIM, 6'd63, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd127}, 8'sd0},
        '{'{lvp_pkg::CMD_UPDATE, 6'd63, 3'd7, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_UPDATE, 6'd63, 3'd0, 1'b1, 1'b0, 1'b0, 32'd5, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd63, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd100}, 8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd63, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0}, 8'sd7},
        '{'{lvp_pkg::CMD_UPDATE, 6'd63, 3'd3, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd63, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd99}, 8'sd7},
        '{'{lvp_pkg::CMD_VICTIM, 6'd63, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd127}, 8'sd1},
        '{'{lvp_pkg::CMD_UPDATE, 6'd1, 3'd2, 1'b0, 1'b0, 1'b1, 32'd100, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_UPDATE, 6'd1, 3'd6, 1'b1, 1'b0, 1'b1, 32'd100, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd1, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0}, 8'sd6},
        '{'{lvp_pkg::CMD_UPDATE, 6'd2, 3'd4, 1'b0, 1'b0, 1'b1, 32'd0, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd2, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0}, 8'sd4},
        '{'{lvp_pkg::CMD_UPDATE, 6'd3, 3'd5, 1'b0, 1'b1, 1'b1, 32'd7, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd3, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0}, 8'sd5},
        '{'{lvp_pkg::CMD_UPDATE, 6'd3, 3'd5, 1'b1, 1'b0, 1'b0, 32'd9, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd3, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0}, 8'sd0},
        '{'{lvp_pkg::CMD_UPDATE, 6'd4, 3'd0, 1'b0, 1'b0, 1'b0, 32'd50, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_UPDATE, 6'd4, 3'd1, 1'b1, 1'b0, 1'b1, 32'd10, 7'd0}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd4, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd127}, -8'sd1},
        '{'{lvp_pkg::CMD_VICTIM, 6'd4, 3'd0, 1'b0, 1'b0, 1'b0, 32'd0, 7'd0}, -8'sd1}
    };

    localparam logic [lvp_pkg::PCT_W-1:0] PHASE_PCT [5] = '{7'd0, 7'd127, 7'd50, 7'd1, 7'd99};

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [lvp_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [lvp_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lvp_pkg::PCT_W-1:0]     cfg_data;

    logic [lvp_pkg::NOW_W-1:0] stamp_mem [lvp_pkg::SETS_DEF][lvp_pkg::WAYS_DEF];
    logic                      instr_mem [lvp_pkg::SETS_DEF][lvp_pkg::WAYS_DEF];
    logic [lvp_pkg::PCT_W-1:0] evict_pct;
    logic [2:0]                victim_q [$];
    int                        err_cnt;
    bit                        no_idle;

    lru_victim_prob_instr_evict uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [2:0] pick_victim(input logic [5:0] s, input logic [6:0] rnd);
        logic [2:0]                v;
        logic [lvp_pkg::NOW_W-1:0] best;
        logic [lvp_pkg::NOW_W-1:0] newest;
        v = 3'd0;
        best = stamp_mem[s][0];
        for (int w = 1; w < lvp_pkg::WAYS_DEF; w++) begin
            if (stamp_mem[s][w] < best) begin
                best = stamp_mem[s][w];
                v = w[2:0];
            end
        end
        if (rnd < evict_pct) begin
            newest = '0;
            for (int w = 0; w < lvp_pkg::WAYS_DEF; w++) begin
                if (instr_mem[s][w] && newest <= stamp_mem[s][w]) begin
                    newest = stamp_mem[s][w];
                    v = w[2:0];
                end
            end
        end
        return v;
    endfunction

    // returns 1 when the item yields a victim
    function automatic bit track_item(input req_t r, output logic [2:0] way);
        way = 3'd0;
        if (r.cmd == lvp_pkg::CMD_UPDATE) begin
            if (!(r.hit && r.wr)) begin
                stamp_mem[r.set_idx][r.way] = r.tnow;
                instr_mem[r.set_idx][r.way] = r.instr;
            end
            return 1'b0;
        end
        way = pick_victim(r.set_idx, r.rnd);
        return 1'b1;
    endfunction

    task automatic send_item(input req_t r, input int want);
        logic [2:0] way;
        while (!no_idle && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {5'b0, r.rnd, r.tnow, r.instr, r.wr, r.hit, r.way, r.set_idx};
        do @(posedge aclk); while (!s_tready);
        if (track_item(r, way))
            victim_q.push_back(want == FROM_PREDICTOR ? way : want[2:0]);
    endtask

    task automatic write_pct(input logic [lvp_pkg::PCT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        evict_pct = v;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (victim_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic req_t random_req(inout logic [lvp_pkg::NOW_W-1:0] clk_now);
        req_t r;
        r.cmd     = ($urandom_range(0, 99) < 55) ? lvp_pkg::CMD_UPDATE : lvp_pkg::CMD_VICTIM;
        r.set_idx = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 3))
                                               : 6'($urandom_range(0, 63));
        r.way     = 3'($urandom_range(0, 7));
        r.hit     = 1'($urandom);
        r.wr      = 1'($urandom);
        r.instr   = 1'($urandom);
        case ($urandom_range(0, 19))
            0: r.tnow = '0;
            1: r.tnow = '1;
            2, 3: r.tnow = $urandom;
            default: begin
                clk_now = clk_now + lvp_pkg::NOW_W'($urandom_range(1, 20));
                r.tnow = clk_now;
            end
        endcase
        r.rnd = 7'($urandom_range(0, 127));
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        logic [2:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (victim_q.size() == 0) begin
                if (err_cnt < 10)
                    $display("%0t: victim transfer %0d with none pending", $realtime, m_tdata[2:0]);
                err_cnt++;
            end else begin
                want = victim_q.pop_front();
                if (m_tdata[2:0] !== want) begin
                    if (err_cnt < 10)
                        $display("%0t: victim_way expected %0d got %0d",
                                 $realtime, want, m_tdata[2:0]);
                    err_cnt++;
                end
            end
        end
    end

    // result side, with one long hold-off
    initial begin
        int  seen;
        int  hold;
        bit  held;
        seen = 0;
        hold = 0;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                seen++;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!held && seen >= HOLD_AFTER) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial begin
        logic [lvp_pkg::NOW_W-1:0] clk_now;
        int                        n;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        err_cnt   = 0;
        no_idle   = 1'b0;
        evict_pct = '0;
        clk_now   = '0;
        n         = 0;
        for (int s = 0; s < lvp_pkg::SETS_DEF; s++) begin
            for (int w = 0; w < lvp_pkg::WAYS_DEF; w++) begin
                stamp_mem[s][w] = '0;
                instr_mem[s][w] = 1'b0;
            end
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_pct(7'd100);
        for (int i = 0; i < NPROBES; i++)
            send_item(PROBES[i].req, int'(PROBES[i].want));
        drain();

        for (int p = 0; p < $size(PHASE_PCT); p++) begin
            write_pct(PHASE_PCT[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                no_idle = (n >= QUIET_FIRST && n <= QUIET_LAST);
                send_item(random_req(clk_now), FROM_PREDICTOR);
                n++;
            end
            no_idle = 1'b0;
            drain();
        end

        if (err_cnt == 0 && victim_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/lvp_pkg.sv
hdl/lvp_ram.sv
hdl/lvp_tree.sv
hdl/lru_victim_prob_instr_evict.sv
bench/tb_lru_victim_prob_instr_evict.sv
